@@ sv/dqe_pkg.sv @@
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types and constants for the double-ended queue block.
// ----------------------------------------------------------------------------
`default_nettype none

package dqe_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int WORD_W     = 32;
	localparam int OP_W       = 3;
	localparam int STATUS_W   = 2;
	localparam int CMDQ_DEPTH = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_LIST       = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_UNDERFLOW = 2'd1,
		STS_OVERFLOW  = 2'd2,
		STS_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_PUSH = 2'd0,
		K_POP  = 2'd1,
		K_LIST = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_POP  = 2'd1,
		FSM_LIST = 2'd2
	} fsm_t;

	// decoded command as it sits in the queue
	typedef struct packed {
		kind_t              kind;
		logic               front;
		logic signed [WORD_W-1:0] value;
	} cmd_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmdq_head_t;

endpackage

`default_nettype wire

@@ sv/dqe_front.sv @@
// ----------------------------------------------------------------------------
// dqe_front
// Accepts input items and decodes them into queue commands; unused op codes
// are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module dqe_front (
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [dqe_pkg::OP_W-1:0]           op,
	input  wire logic signed [dqe_pkg::WORD_W-1:0]  value,
	input  wire logic                               cmdq_full,
	output logic                                    cmdq_push,
	output dqe_pkg::cmd_t                           cmdq_cmd
);

	logic known;

	always_comb begin
		known          = 1'b1;
		cmdq_cmd.kind  = dqe_pkg::K_PUSH;
		cmdq_cmd.front = 1'b0;
		cmdq_cmd.value = value;
		unique case (op)
			dqe_pkg::OP_PUSH_FRONT: begin
				cmdq_cmd.kind  = dqe_pkg::K_PUSH;
				cmdq_cmd.front = 1'b1;
			end
			dqe_pkg::OP_PUSH_REAR: begin
				cmdq_cmd.kind  = dqe_pkg::K_PUSH;
			end
			dqe_pkg::OP_POP_FRONT: begin
				cmdq_cmd.kind  = dqe_pkg::K_POP;
				cmdq_cmd.front = 1'b1;
			end
			dqe_pkg::OP_POP_REAR: begin
				cmdq_cmd.kind  = dqe_pkg::K_POP;
			end
			dqe_pkg::OP_LIST: begin
				cmdq_cmd.kind  = dqe_pkg::K_LIST;
				cmdq_cmd.front = 1'b1;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign in_stall  = cmdq_full;
	assign cmdq_push = in_valid && !cmdq_full && known;

endmodule

`default_nettype wire

@@ sv/dqe_cmdq.sv @@
// ----------------------------------------------------------------------------
// dqe_cmdq
// Short command queue between the decode front end and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dqe_cmdq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire dqe_pkg::cmd_t       push_cmd,
	output logic                     full,
	input  wire logic                pop,
	output dqe_pkg::cmdq_head_t      head
);

	localparam int PW = (dqe_pkg::CMDQ_DEPTH > 1) ? $clog2(dqe_pkg::CMDQ_DEPTH) : 1;
	localparam int NW = $clog2(dqe_pkg::CMDQ_DEPTH + 1);

	dqe_pkg::cmd_t entry_q [dqe_pkg::CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(dqe_pkg::CMDQ_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign full       = (fill_q == NW'(dqe_pkg::CMDQ_DEPTH));
	assign head.valid = (fill_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/dqe_back.sv @@
// ----------------------------------------------------------------------------
// dqe_back
// Executes queued commands against the circular store and drives the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqe_back #(
	parameter int DEPTH = dqe_pkg::DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dqe_pkg::cmdq_head_t                cq_head,
	output logic                                    cq_pop,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [dqe_pkg::STATUS_W-1:0]            status,
	output logic signed [dqe_pkg::WORD_W-1:0]       data,
	output logic                                    last
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dqe_pkg::fsm_t                    state_q, state_d;
	logic [AW-1:0]                    head_q, head_d;
	logic [CW-1:0]                    count_q, count_d;
	logic [CW-1:0]                    idx_q, idx_d;
	logic signed [dqe_pkg::WORD_W-1:0] mem_q [DEPTH];
	logic signed [dqe_pkg::WORD_W-1:0] rd_data_q;

	logic                             out_valid_q;
	dqe_pkg::status_t                 status_q;
	logic signed [dqe_pkg::WORD_W-1:0] data_q;
	logic                             last_q;

	logic                             out_free;
	logic                             full;
	logic                             empty;
	logic                             list_end;
	logic [AW-1:0]                    head_dec;

	logic                             load;
	dqe_pkg::status_t                 ld_status;
	logic signed [dqe_pkg::WORD_W-1:0] ld_data;
	logic                             ld_last;
	logic                             wr_en;
	logic [AW-1:0]                    wr_addr;
	logic                             rd_en;
	logic [AW-1:0]                    rd_addr;

	// (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] off);
		logic [CW:0] s;
		s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
		if (s >= (CW + 1)'(DEPTH)) begin
			s = s - (CW + 1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign list_end = (CW'(idx_q + 1'b1) == count_q);
	assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : AW'(head_q - 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dqe_pkg::FSM_IDLE: begin
				if (cq_head.valid && !empty) begin
					if (cq_head.cmd.kind == dqe_pkg::K_POP) begin
						state_d = dqe_pkg::FSM_POP;
					end else if (cq_head.cmd.kind == dqe_pkg::K_LIST) begin
						state_d = dqe_pkg::FSM_LIST;
					end
				end
			end
			dqe_pkg::FSM_POP: begin
				if (out_free) begin
					state_d = dqe_pkg::FSM_IDLE;
				end
			end
			dqe_pkg::FSM_LIST: begin
				if (out_free && list_end) begin
					state_d = dqe_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = dqe_pkg::FSM_IDLE;
			end
		endcase
	end

	// datapath control
	always_comb begin
		cq_pop    = 1'b0;
		load      = 1'b0;
		ld_status = dqe_pkg::STS_OK;
		ld_data   = '0;
		ld_last   = 1'b1;
		wr_en     = 1'b0;
		wr_addr   = head_q;
		rd_en     = 1'b0;
		rd_addr   = head_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		unique case (state_q)
			dqe_pkg::FSM_IDLE: begin
				if (cq_head.valid) begin
					unique case (cq_head.cmd.kind)
						dqe_pkg::K_PUSH: begin
							if (out_free) begin
								cq_pop = 1'b1;
								load   = 1'b1;
								if (full) begin
									ld_status = dqe_pkg::STS_OVERFLOW;
								end else begin
									wr_en   = 1'b1;
									count_d = count_q + 1'b1;
									if (cq_head.cmd.front) begin
										wr_addr = head_dec;
										head_d  = head_dec;
									end else begin
										wr_addr = wrap_add(head_q, count_q);
									end
								end
							end
						end
						dqe_pkg::K_POP: begin
							if (empty) begin
								if (out_free) begin
									cq_pop    = 1'b1;
									load      = 1'b1;
									ld_status = dqe_pkg::STS_UNDERFLOW;
								end
							end else begin
								// read now, result goes out from the POP state
								cq_pop  = 1'b1;
								rd_en   = 1'b1;
								count_d = count_q - 1'b1;
								if (cq_head.cmd.front) begin
									rd_addr = head_q;
									head_d  = wrap_add(head_q, CW'(1));
								end else begin
									rd_addr = wrap_add(head_q, CW'(count_q - 1'b1));
								end
							end
						end
						dqe_pkg::K_LIST: begin
							if (empty) begin
								if (out_free) begin
									cq_pop    = 1'b1;
									load      = 1'b1;
									ld_status = dqe_pkg::STS_EMPTY;
								end
							end else begin
								cq_pop  = 1'b1;
								rd_en   = 1'b1;
								rd_addr = head_q;
								idx_d   = '0;
							end
						end
						default: begin
							cq_pop = 1'b1;
						end
					endcase
				end
			end
			dqe_pkg::FSM_POP: begin
				if (out_free) begin
					load    = 1'b1;
					ld_data = rd_data_q;
				end
			end
			dqe_pkg::FSM_LIST: begin
				if (out_free) begin
					load    = 1'b1;
					ld_data = rd_data_q;
					ld_last = list_end;
					if (!list_end) begin
						// prefetch the next entry while this one goes out
						idx_d   = idx_q + 1'b1;
						rd_en   = 1'b1;
						rd_addr = wrap_add(head_q, CW'(idx_q + 1'b1));
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= cq_head.cmd.value;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (load) begin
			status_q <= ld_status;
			data_q   <= ld_data;
			last_q   <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dqe_pkg::FSM_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_list_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dqe_pkg::FSM_LIST |-> idx_q < count_q)
		else $error("list index past last entry");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		load && ld_status == dqe_pkg::STS_OVERFLOW |-> full && !wr_en)
		else $error("overflow reported on a non-full store");

	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dqe_pkg::FSM_POP && out_free
		|=> out_valid_q && last_q && state_q == dqe_pkg::FSM_IDLE)
		else $error("pop result not delivered");
`endif

endmodule

`default_nettype wire

@@ sv/double_ended_queue_top.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit words with list readout.
// ----------------------------------------------------------------------------
// Items enter a two-entry command queue one per cycle while it has room, so
// the input side keeps moving while the back end works. A push writes the
// store and loads its result at once; a pop first reads the store into a
// register and then loads the result from it; a listing reads the store once
// per entry, each read ahead of the load of that entry's result. An empty
// pop, empty listing or overflowing push loads its status result without a
// store read. Results leave through a register that holds while stalled. Op
// codes five to seven are accepted and give no result.
`default_nettype none

module double_ended_queue_top #(
	parameter int DEPTH = dqe_pkg::DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [dqe_pkg::OP_W-1:0]           op,
	input  wire logic signed [dqe_pkg::WORD_W-1:0]  value,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [dqe_pkg::STATUS_W-1:0]            status,
	output logic signed [dqe_pkg::WORD_W-1:0]       data,
	output logic                                    last
);

	logic                 cmdq_full;
	logic                 cmdq_push;
	dqe_pkg::cmd_t        cmdq_cmd;
	logic                 cq_pop;
	dqe_pkg::cmdq_head_t  cq_head;

	dqe_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.value     (value),
		.cmdq_full (cmdq_full),
		.cmdq_push (cmdq_push),
		.cmdq_cmd  (cmdq_cmd)
	);

	dqe_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmdq_push),
		.push_cmd (cmdq_cmd),
		.full     (cmdq_full),
		.pop      (cq_pop),
		.head     (cq_head)
	);

	dqe_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_head   (cq_head),
		.cq_pop    (cq_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.data      (data),
		.last      (last)
	);

endmodule

`default_nettype wire
